[rtl/gf16_matrix_vector_multiply_unit_assert.svh]
// Assertion macros used by the checker.
`ifndef GF16_MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`define GF16_MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define GFMV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfmv assertion failed");

// Next-cycle implication, off while reset is high.
`define GFMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfmv assertion failed");

// Next-cycle implication that also holds across reset.
`define GFMV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gfmv assertion failed");

`endif

[rtl/gfmv_pkg.sv]
`default_nettype none

package gfmv_pkg;

   localparam int FIELD_BITS     = 4;
   localparam int NUM_ROWS       = 8;
   localparam int WORD_BITS      = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int FIELD_SIZE     = 1 << FIELD_BITS;

   // Register index of row 0; row r sits at CSR_ROW_BASE + r.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_BASE = '0;

   // Multiply by x modulo x^4+x^3+x^2+x+1.
   localparam logic [FIELD_BITS-1:0] XTIME_TABLE [0:FIELD_SIZE-1] = '{
      4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14,
      4'd15, 4'd13, 4'd11, 4'd9, 4'd7, 4'd5, 4'd3, 4'd1
   };

   typedef logic [FIELD_BITS-1:0] digit_type;
   typedef logic [WORD_BITS-1:0]  word_type;

   typedef struct packed {
      logic                      en;
      logic [CSR_INDEX_BITS-1:0] index;
      word_type                  data;
   } csr_write_type;

   // Shift-and-add field product.
   function automatic digit_type gf_mul(input digit_type a, input digit_type b);
      digit_type acc;
      digit_type sh;
      acc = '0;
      sh  = a;
      for (int idx = 0; idx < FIELD_BITS; idx++) begin
         if (b[idx]) begin
            acc = acc ^ sh;
         end
         sh = XTIME_TABLE[sh];
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

[rtl/gfmv_row_regs.sv]
`default_nettype none

module gfmv_row_regs #(
   parameter int MATRIX_DIM = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire gfmv_pkg::csr_write_type                       csr_write,
   output logic      [MATRIX_DIM-1:0][gfmv_pkg::WORD_BITS-1:0] rows
);

   logic [MATRIX_DIM-1:0][gfmv_pkg::WORD_BITS-1:0] rows_ff;

   // Rows at or above the dimension never take part, so they are not kept.
   always_ff @(posedge clock) begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
         if (reset) begin
            rows_ff[r] <= '0;
         end else if (csr_write.en &&
                      csr_write.index == gfmv_pkg::CSR_ROW_BASE +
                         gfmv_pkg::CSR_INDEX_BITS'(r)) begin
            rows_ff[r] <= csr_write.data;
         end
      end
   end

   assign rows = rows_ff;

endmodule

`default_nettype wire

[rtl/gfmv_row_dot.sv]
`default_nettype none

module gfmv_row_dot #(
   parameter int MATRIX_DIM = 8
) (
   input  wire logic [gfmv_pkg::WORD_BITS-1:0]  row_word,
   input  wire logic [gfmv_pkg::WORD_BITS-1:0]  vector_word,
   output logic      [gfmv_pkg::FIELD_BITS-1:0] dot_digit
);

   localparam int FB = gfmv_pkg::FIELD_BITS;

   logic [MATRIX_DIM-1:0][FB-1:0] products;

   always_comb begin
      for (int k = 0; k < MATRIX_DIM; k++) begin
         products[k] = gfmv_pkg::gf_mul(row_word[k*FB +: FB], vector_word[k*FB +: FB]);
      end
   end

   // Field addition is XOR over the column products.
   always_comb begin
      dot_digit = '0;
      for (int k = 0; k < MATRIX_DIM; k++) begin
         dot_digit = dot_digit ^ products[k];
      end
   end

endmodule

`default_nettype wire

[rtl/gf16_matrix_vector_multiply_unit.sv]
// GF(16) matrix-vector multiplier. Each request word carries eight packed 4-bit
// digits (digit 0 in the low bits); the response word holds the product of the
// matrix held in row registers csr index 0..7 and that vector, packed the same
// way, with field reduction modulo x^4+x^3+x^2+x+1. One word is taken every
// cycle while the request side is not stalled; a request is registered in the
// input register, passes through the parallel field multiplies and XOR trees,
// and lands in the result register, from which its response is presented.
// A stalled response holds the result register and, once the input register is
// also full, the request side. With MATRIX_DIM below eight, only the low rows
// and columns take part and the upper output digits read zero. Write rows only
// while idle.
`default_nettype none

module gf16_matrix_vector_multiply_unit #(
   parameter int MATRIX_DIM = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [gfmv_pkg::WORD_BITS-1:0]         req_vector_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic      [gfmv_pkg::WORD_BITS-1:0]         rsp_vector_out,
   input  wire logic                                   csr_write_en,
   input  wire logic [gfmv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [gfmv_pkg::WORD_BITS-1:0]         csr_write_data
);

   localparam int FB = gfmv_pkg::FIELD_BITS;
   localparam int WB = gfmv_pkg::WORD_BITS;

   gfmv_pkg::csr_write_type                csr_write;
   logic [MATRIX_DIM-1:0][WB-1:0]          rows;
   logic [MATRIX_DIM-1:0][FB-1:0]          product_digits;
   logic [WB-1:0]                          product_word;

   logic          in_valid_ff, in_valid_in;
   logic [WB-1:0] in_vector_ff;
   logic          out_valid_ff, out_valid_in;
   logic [WB-1:0] out_vector_ff;
   logic          accept;
   logic          advance;

   assign csr_write = '{en: csr_write_en, index: csr_index, data: csr_write_data};

   gfmv_row_regs #(.MATRIX_DIM(MATRIX_DIM)) u_row_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .rows      (rows)
   );

   for (genvar r = 0; r < MATRIX_DIM; r++) begin : g_row
      gfmv_row_dot #(.MATRIX_DIM(MATRIX_DIM)) u_row_dot (
         .row_word    (rows[r]),
         .vector_word (in_vector_ff),
         .dot_digit   (product_digits[r])
      );
   end

   // Upper digits stay zero when the dimension is reduced.
   assign product_word = WB'(product_digits);

   // Advance the result register whenever it is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_vector_ff <= req_vector_in;
      end
      if (advance && in_valid_ff) begin
         out_vector_ff <= product_word;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_vector_out = out_vector_ff;

endmodule

`default_nettype wire

[rtl/gfmv_checker.sv]
`default_nettype none

`include "gf16_matrix_vector_multiply_unit_assert.svh"

module gfmv_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [gfmv_pkg::WORD_BITS-1:0]  rsp_vector_out
);

   // A held response word keeps its valid.
   `GFMV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A held response word keeps its data.
   `GFMV_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_vector_out))

   // The request side backs up only behind a stalled response.
   `GFMV_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A taken word reaches the result register after passing the input register.
   `GFMV_ASSERT_IMPLIES(a_latency, clock, reset, req_valid && !req_stall, ##2 rsp_valid)

   // Reset drops any pending response.
   `GFMV_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind gf16_matrix_vector_multiply_unit gfmv_checker u_gfmv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_vector_out (rsp_vector_out)
);

`default_nettype wire
